// ----- sv/priority_task_scheduler_assert.svh -----
// assertion macros for the task scheduler checker
`ifndef PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the priority task scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    localparam int MAX_TASKS_DEF = 4096;
    localparam int NUM_PRIOS_DEF = 4;

    localparam int KIND_W = 3;
    localparam int PRIO_W = 2;
    localparam int ID_W   = 12;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_SPAWN  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_YIELD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WAIT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WAKE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FINISH = 3'd4;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_ACTIVE  = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;
    localparam logic [1:0] ST_READY   = 2'd3;

    localparam logic [STAT_W-1:0] RES_OK       = 2'd0;
    localparam logic [STAT_W-1:0] RES_NO_SLOT  = 2'd1;
    localparam logic [STAT_W-1:0] RES_NOT_WAIT = 2'd2;
    localparam logic [STAT_W-1:0] RES_ALL_DONE = 2'd3;

endpackage

`default_nettype wire

// ----- sv/pts_ram.sv -----
// ----------------------------------------------------------------------------
// pts_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/priority_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_task_scheduler
// strict-priority task scheduler with fifo ready queues per priority
// ----------------------------------------------------------------------------
// usage
// - slave channel s_axis_*: one request per transfer; tdata holds kind,
//   prio and task_id, kind selects spawn, yield, wait, wake or finish
// - master channel m_axis_*: one result per request; tdata holds
//   next_task, running, new_task and status
// - each request runs through a small sequencer around one read and one
//   write port per table (link, priority, status); the time from
//   acceptance to a valid result is set by the dependent memory reads
//   (a rejected or ignored request goes from decode straight to the
//   result; a yield that switches tasks runs pick, head link read, then
//   the priority read and queue push)
// - the next request is taken only once the last result has been taken
// - s_axis_tready is high only while the sequencer is idle and the
//   result register is empty
// - at reset slot 0 is running at normal priority, all queues are empty;
//   a clearing pass then walks every entry of the status memory, one
//   entry a cycle, while no request is taken
// - a stalled receiver holds the result in the output register; the
//   block takes no new request until it has been taken
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
    parameter int NUM_PRIOS = pts_pkg::NUM_PRIOS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // kind[2:0], prio[4:3], task_id[16:5], zero fill [23:17]
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // next_task[11:0], running[12], new_task[24:13], status[26:25],
    // zero fill [31:27]
    output logic      [31:0] m_axis_tdata
);

    import pts_pkg::*;

    localparam int AW  = $clog2(MAX_TASKS);
    localparam int PW  = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;
    localparam int CW  = AW + 1;
    localparam logic [PRIO_W-1:0] MAIN_PRIO = (NUM_PRIOS > 1) ? 2'd1 : 2'd0;
    localparam logic [PRIO_W-1:0] TOP_PRIO  = PRIO_W'(NUM_PRIOS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_FREE_RD, S_WAKE_RD, S_PICK, S_PICK_RD,
        S_PUSH_PRIO, S_PUSH, S_OUT
    } state_t;

    // what to do after a pick completes
    typedef enum logic [1:0] { P_YIELD, P_DISPATCH } pmode_t;

    state_t state_reg;
    pmode_t pmode_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [AW-1:0]     id_reg;
    logic              id_ok_reg;

    logic [AW-1:0]   head_reg [NUM_PRIOS];
    logic [AW-1:0]   tail_reg [NUM_PRIOS];
    logic [NUM_PRIOS-1:0] qvalid_reg;
    logic [AW-1:0]   free_top_reg;
    logic            free_valid_reg;
    logic [AW-1:0]   fresh_reg;
    logic [AW-1:0]   cur_reg;
    logic            run_reg;
    logic [CW-1:0]   wait_cnt_reg;
    logic [AW-1:0]   pick_slot_reg;
    logic [PW-1:0]   pick_p_reg;
    logic [AW-1:0]   new_reg;
    logic [STAT_W-1:0] stat_reg;
    logic [AW-1:0]   push_slot_reg;
    logic [AW:0]     clr_reg;

    logic [31:0] out_reg;
    logic        out_valid_reg;

    // memory ports
    logic            lk_we, pr_we, st_we;
    logic [AW-1:0]   lk_wa, lk_ra, pr_wa, pr_ra, st_wa, st_ra;
    logic [AW-1:0]   lk_wd, lk_rd;
    logic [PRIO_W-1:0] pr_wd, pr_rd;
    logic [1:0]      st_wd, st_rd;

    pts_ram #(.WIDTH(AW), .DEPTH(MAX_TASKS)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
    pts_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_prio (
        .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd));
    pts_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_stat (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

    // best non-empty queue
    logic          any_q;
    logic [PW-1:0] best_p;
    always_comb
    begin
        any_q  = 1'b0;
        best_p = '0;
        for (int i = NUM_PRIOS - 1; i >= 0; i--)
        begin
            if (qvalid_reg[i])
            begin
                any_q  = 1'b1;
                best_p = PW'(i);
            end
        end
    end

    logic [PRIO_W-1:0] prio_clamp;
    assign prio_clamp = (32'(s_axis_tdata[4:3]) >= NUM_PRIOS) ? TOP_PRIO : s_axis_tdata[4:3];

    logic [PW-1:0] pq;
    assign pq = PW'(pr_rd);

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // memory port drive, all by state
    always_comb
    begin
        lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = '0;
        pr_we = 1'b0; pr_wa = '0; pr_wd = '0; pr_ra = '0;
        st_we = 1'b0; st_wa = '0; st_wd = ST_EMPTY; st_ra = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                st_we = 1'b1;
                st_wa = clr_reg[AW-1:0];
                st_wd = (clr_reg == '0) ? ST_ACTIVE : ST_EMPTY;
                pr_we = (clr_reg == '0);
                pr_wd = MAIN_PRIO;
            end
            S_IDLE:
            begin
                lk_ra = free_top_reg;
                st_ra = AW'(s_axis_tdata[16:5]);
            end
            S_DEC:
            begin
                lk_ra = free_top_reg;
                pr_ra = id_reg;
                st_ra = id_reg;
                if (kind_reg == KIND_WAIT && run_reg)
                begin
                    st_we = 1'b1; st_wa = cur_reg; st_wd = ST_WAITING;
                end
                else if (kind_reg == KIND_FINISH && run_reg)
                begin
                    st_we = 1'b1; st_wa = cur_reg; st_wd = ST_EMPTY;
                    lk_we = (cur_reg != '0);
                    lk_wa = cur_reg;
                    lk_wd = free_valid_reg ? free_top_reg : cur_reg;
                end
            end
            S_PICK:
            begin
                lk_ra = head_reg[best_p];
                pr_ra = cur_reg;
            end
            S_PICK_RD:
            begin
                st_we = 1'b1; st_wa = pick_slot_reg; st_wd = ST_ACTIVE;
                pr_ra = push_slot_reg;
            end
            S_PUSH_PRIO:
            begin
                pr_ra = push_slot_reg;
            end
            S_PUSH:
            begin
                st_we = 1'b1; st_wa = push_slot_reg; st_wd = ST_READY;
                if (kind_reg == KIND_WAKE)
                begin
                    lk_we = qvalid_reg[pq]; lk_wa = push_slot_reg; lk_wd = head_reg[pq];
                end
                else
                begin
                    lk_we = qvalid_reg[pq]; lk_wa = tail_reg[pq]; lk_wd = push_slot_reg;
                end
            end
            S_FREE_RD:
            begin
                pr_we = 1'b1; pr_wa = push_slot_reg; pr_wd = prio_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pmode_reg      <= P_DISPATCH;
            qvalid_reg     <= '0;
            free_valid_reg <= 1'b0;
            fresh_reg      <= '0;
            cur_reg        <= '0;
            run_reg        <= 1'b1;
            wait_cnt_reg   <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == MAX_TASKS - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        kind_reg  <= s_axis_tdata[2:0];
                        prio_reg  <= prio_clamp;
                        id_reg    <= AW'(s_axis_tdata[16:5]);
                        id_ok_reg <= (32'(s_axis_tdata[16:5]) < MAX_TASKS);
                        new_reg   <= '0;
                        stat_reg  <= RES_OK;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    // lk_rd holds link of free top, st_rd status of id
                    unique case (kind_reg)
                        KIND_SPAWN:
                        begin
                            if (free_valid_reg)
                            begin
                                push_slot_reg <= free_top_reg;
                                new_reg       <= free_top_reg;
                                if (lk_rd == free_top_reg)
                                    free_valid_reg <= 1'b0;
                                else
                                    free_top_reg <= lk_rd;
                                state_reg <= S_FREE_RD;
                            end
                            else if (32'(fresh_reg) + 1 < MAX_TASKS)
                            begin
                                fresh_reg     <= fresh_reg + 1'b1;
                                push_slot_reg <= fresh_reg + 1'b1;
                                new_reg       <= fresh_reg + 1'b1;
                                state_reg     <= S_FREE_RD;
                            end
                            else
                            begin
                                stat_reg  <= RES_NO_SLOT;
                                state_reg <= S_OUT;
                            end
                        end
                        KIND_YIELD:
                        begin
                            pmode_reg <= run_reg ? P_YIELD : P_DISPATCH;
                            state_reg <= S_PICK;
                        end
                        KIND_WAIT:
                        begin
                            if (run_reg)
                            begin
                                wait_cnt_reg <= wait_cnt_reg + 1'b1;
                                pmode_reg    <= P_DISPATCH;
                                state_reg    <= S_PICK;
                            end
                            else
                                state_reg <= S_OUT;
                        end
                        KIND_WAKE:
                        begin
                            if (id_ok_reg && st_rd == ST_WAITING)
                            begin
                                push_slot_reg <= id_reg;
                                if (wait_cnt_reg != '0)
                                    wait_cnt_reg <= wait_cnt_reg - 1'b1;
                                state_reg <= S_PUSH_PRIO;
                            end
                            else
                            begin
                                stat_reg  <= RES_NOT_WAIT;
                                state_reg <= S_OUT;
                            end
                        end
                        KIND_FINISH:
                        begin
                            if (run_reg)
                            begin
                                if (cur_reg != '0)
                                begin
                                    free_top_reg   <= cur_reg;
                                    free_valid_reg <= 1'b1;
                                end
                                pmode_reg <= P_DISPATCH;
                                state_reg <= S_PICK;
                            end
                            else
                                state_reg <= S_OUT;
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_FREE_RD:
                begin
                    state_reg <= S_PUSH_PRIO;
                end
                S_PICK:
                begin
                    if (any_q)
                    begin
                        pick_slot_reg <= head_reg[best_p];
                        pick_p_reg    <= best_p;
                        push_slot_reg <= cur_reg;
                        state_reg     <= S_PICK_RD;
                    end
                    else
                    begin
                        if (pmode_reg == P_DISPATCH)
                            run_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_PICK_RD:
                begin
                    if (head_reg[pick_p_reg] == tail_reg[pick_p_reg])
                        qvalid_reg[pick_p_reg] <= 1'b0;
                    else
                        head_reg[pick_p_reg] <= lk_rd;
                    cur_reg <= pick_slot_reg;
                    run_reg <= 1'b1;
                    // yielding task goes to the newest end of its queue
                    state_reg <= (pmode_reg == P_YIELD) ? S_PUSH_PRIO : S_OUT;
                end
                S_PUSH_PRIO:
                begin
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    if (!qvalid_reg[pq])
                    begin
                        head_reg[pq]   <= push_slot_reg;
                        tail_reg[pq]   <= push_slot_reg;
                        qvalid_reg[pq] <= 1'b1;
                    end
                    else if (kind_reg == KIND_WAKE)
                        head_reg[pq] <= push_slot_reg;
                    else
                        tail_reg[pq] <= push_slot_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_reg <= {5'd0,
                                ((kind_reg == KIND_YIELD || kind_reg == KIND_WAIT ||
                                  kind_reg == KIND_FINISH) && !run_reg &&
                                 wait_cnt_reg == '0 && !any_q) ? RES_ALL_DONE : stat_reg,
                                12'(new_reg),
                                run_reg,
                                run_reg ? 12'(cur_reg) : 12'd0};
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker
// port-level checks of the priority task scheduler
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_task_scheduler_assert.svh"

module pts_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [23:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    `PTS_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `PTS_ASSERT_IMPL(a_no_take_busy, clk, rst_n, m_axis_tvalid, !s_axis_tready, "request taken with result pending")
    `PTS_ASSERT_IMPL(a_idle_zero, clk, rst_n, m_axis_tvalid && !m_axis_tdata[12], m_axis_tdata[11:0] == 12'd0, "idle result names a task")
    `PTS_ASSERT_NEXT(a_one_result, clk, rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result without work")

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the priority task scheduler: directed requests
// followed by random spawn/yield/wait/wake/finish traffic, each result
// checked against a behavioral scheduler model kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import pts_pkg::*;

    localparam int NTASK = MAX_TASKS_DEF;
    localparam int NPRIO = NUM_PRIOS_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    // first member in the top bits, so next_task lands in the low bits
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] new_task;
        logic        running;
        logic [11:0] next_task;
    } sched_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    priority_task_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model state of the scheduler
    logic [11:0] mdl_link [NTASK];
    logic [1:0]  mdl_prio [NTASK];
    logic [1:0]  mdl_stat [NTASK];
    logic [11:0] q_head [NPRIO];
    logic [11:0] q_tail [NPRIO];
    bit          q_vld [NPRIO];
    logic [11:0] free_top;
    bit          free_vld;
    int          fresh_cnt;
    logic [11:0] cur_slot;
    bit          is_run;
    int          wait_cnt;

    sched_res_t  expected_results [$];
    int          mismatches;
    longint      cycles;
    bit          hold_long;      // receiver holds off while set

    task automatic sched_reset();
        for (int i = 0; i < NTASK; i++)
        begin
            mdl_link[i] = '0;
            mdl_prio[i] = '0;
            mdl_stat[i] = ST_EMPTY;
        end
        for (int p = 0; p < NPRIO; p++)
        begin
            q_head[p] = '0;
            q_tail[p] = '0;
            q_vld[p]  = 0;
        end
        mdl_prio[0] = 2'd1;
        mdl_stat[0] = ST_ACTIVE;
        free_top  = '0;
        free_vld  = 0;
        fresh_cnt = 0;
        cur_slot  = '0;
        is_run    = 1;
        wait_cnt  = 0;
    endtask

    function automatic void push_newest(logic [11:0] s);
        int p;
        p = mdl_prio[s];
        if (q_vld[p])
        begin
            mdl_link[q_tail[p]] = s;
            q_tail[p] = s;
        end
        else
        begin
            q_head[p] = s;
            q_tail[p] = s;
            q_vld[p]  = 1;
        end
        mdl_stat[s] = ST_READY;
    endfunction

    function automatic void push_oldest(logic [11:0] s);
        int p;
        p = mdl_prio[s];
        if (q_vld[p])
        begin
            mdl_link[s] = q_head[p];
            q_head[p] = s;
        end
        else
        begin
            q_head[p] = s;
            q_tail[p] = s;
            q_vld[p]  = 1;
        end
        mdl_stat[s] = ST_READY;
    endfunction

    // take oldest task of the best non-empty queue
    function automatic bit pick_ready(output logic [11:0] s);
        s = '0;
        for (int p = 0; p < NPRIO; p++)
        begin
            if (q_vld[p])
            begin
                s = q_head[p];
                if (s == q_tail[p])
                    q_vld[p] = 0;
                else
                    q_head[p] = mdl_link[s];
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void dispatch();
        logic [11:0] s;
        if (pick_ready(s))
        begin
            cur_slot = s;
            mdl_stat[s] = ST_ACTIVE;
            is_run = 1;
        end
        else
            is_run = 0;
    endfunction

    function automatic sched_res_t schedule(logic [2:0] kind, logic [1:0] prio,
                                            logic [11:0] id);
        sched_res_t  r;
        logic [11:0] s;
        bit          got, any;
        r = '0;
        if (kind == KIND_SPAWN)
        begin
            got = 1;
            if (free_vld)
            begin
                s = free_top;
                if (mdl_link[s] == s)
                    free_vld = 0;
                else
                    free_top = mdl_link[s];
            end
            else if (fresh_cnt + 1 < NTASK)
            begin
                fresh_cnt++;
                s = fresh_cnt[11:0];
            end
            else
            begin
                got = 0;
                s = '0;
            end
            if (got)
            begin
                mdl_prio[s] = prio;
                push_newest(s);
                r.new_task = s;
            end
            else
                r.status = RES_NO_SLOT;
        end
        else if (kind == KIND_YIELD)
        begin
            if (is_run)
            begin
                if (pick_ready(s))
                begin
                    push_newest(cur_slot);
                    cur_slot = s;
                    mdl_stat[s] = ST_ACTIVE;
                end
            end
            else
                dispatch();
        end
        else if (kind == KIND_WAIT)
        begin
            if (is_run)
            begin
                mdl_stat[cur_slot] = ST_WAITING;
                wait_cnt++;
                dispatch();
            end
        end
        else if (kind == KIND_WAKE)
        begin
            if (mdl_stat[id] == ST_WAITING)
            begin
                push_oldest(id);
                if (wait_cnt > 0)
                    wait_cnt--;
            end
            else
                r.status = RES_NOT_WAIT;
        end
        else if (kind == KIND_FINISH)
        begin
            if (is_run)
            begin
                s = cur_slot;
                mdl_stat[s] = ST_EMPTY;
                if (s != 0)
                begin
                    mdl_link[s] = free_vld ? free_top : s;
                    free_top = s;
                    free_vld = 1;
                end
                dispatch();
            end
        end
        any = 0;
        for (int p = 0; p < NPRIO; p++)
            any |= q_vld[p];
        if ((kind == KIND_YIELD || kind == KIND_WAIT || kind == KIND_FINISH) &&
            !is_run && wait_cnt == 0 && !any)
            r.status = RES_ALL_DONE;
        r.next_task = is_run ? cur_slot : '0;
        r.running   = is_run;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request, record its expected result at the transfer
    task automatic send_req(logic [2:0] kind, logic [1:0] prio, logic [11:0] id);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, id, prio, kind};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(schedule(kind, prio, id));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // pick a currently waiting slot, or any slot if none waits
    function automatic logic [11:0] waiting_slot();
        int base;
        base = $urandom_range(0, NTASK - 1);
        if (wait_cnt != 0)
            for (int i = 0; i < NTASK; i++)
                if (mdl_stat[(base + i) % NTASK] == ST_WAITING)
                    return 12'((base + i) % NTASK);
        return 12'(base);
    endfunction

    task automatic test_directed();
        send_req(KIND_YIELD, 2'd0, 12'd0);       // nothing else ready
        send_req(KIND_WAKE, 2'd0, 12'hFFF);      // bad wake
        send_req(KIND_WAKE, 2'd3, 12'd0);        // slot active, not waiting
        send_req(KIND_SPAWN, 2'd3, 12'hFFF);
        send_req(KIND_SPAWN, 2'd0, 12'd0);
        send_req(KIND_SPAWN, 2'd1, 12'd0);
        send_req(KIND_SPAWN, 2'd2, 12'd0);
        send_req(KIND_YIELD, 2'd0, 12'd0);
        send_req(KIND_WAIT, 2'd0, 12'd0);
        send_req(KIND_WAKE, 2'd0, 12'd2);
        send_req(KIND_YIELD, 2'd0, 12'd0);
        send_req(KIND_FINISH, 2'd0, 12'd0);
        send_req(3'd5, 2'd3, 12'hAAA);            // unused kinds
        send_req(3'd6, 2'd0, 12'h555);
        send_req(3'd7, 2'd1, 12'd0);
        for (int i = 0; i < 8; i++)
            send_req(KIND_FINISH, 2'd0, 12'd0);   // main task too, then idle
        send_req(KIND_WAIT, 2'd0, 12'd0);
        send_req(KIND_YIELD, 2'd0, 12'd0);
        wait_drain();
    endtask

    task automatic test_random(int n);
        int r;
        logic [2:0] k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30) k = KIND_SPAWN;
            else if (r < 50) k = KIND_YIELD;
            else if (r < 65) k = KIND_WAIT;
            else if (r < 82) k = KIND_WAKE;
            else if (r < 97) k = KIND_FINISH;
            else k = 3'($urandom_range(5, 7));
            send_req(k, 2'($urandom_range(0, 3)),
                     ($urandom_range(0, 3) == 0) ? 12'($urandom) : waiting_slot());
        end
    endtask

    // receiver stalls long while requests keep coming, then a drain pause
    task automatic test_backpressure();
        hold_long = 1;
        test_random(20);
        wait_drain();
    endtask

    // a run of spawns, reusing freed slots before fresh ones, then mixed traffic
    task automatic test_spawn_burst();
        for (int i = 0; i < 150; i++)
            send_req(KIND_SPAWN, 2'($urandom_range(0, 3)), 12'd0);
        test_random(100);
        wait_drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        sched_res_t got, exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[26:0];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r || m_axis_tdata[31:27] !== 5'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 exp_r.next_task, exp_r.running, exp_r.new_task,
                                 exp_r.status, got.next_task, got.running,
                                 got.new_task, got.status);
                end
            end
        end
    end

    // receiver ready, with gaps and one long hold-off
    initial
    begin
        int g, hold;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                hold = 0;
                while (hold < 300)
                begin
                    @(posedge clk);
                    hold++;
                end
                hold_long = 0;
            end
            g = gap_len();
            if (g != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("priority_task_scheduler: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;
        mismatches    = 0;
        hold_long     = 0;
        sched_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(500);
        test_backpressure();
        test_random(400);
        wait_drain();
        test_spawn_burst();
        wait_drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("priority_task_scheduler: match");
        else
            $display("priority_task_scheduler: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/pts_pkg.sv
sv/pts_ram.sv
sv/priority_task_scheduler.sv
sv/pts_checker.sv
dv/tb.sv
